>>> hdl/fclp_pkg.sv
// Types and constants for the framed command line parser.
package fclp_pkg;

  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_BODY  = 5'b00010,
    PH_HEX   = 5'b00100,
    PH_TAIL  = 5'b01000,
    PH_BAD   = 5'b10000
  } phase_t;

  typedef logic [2:0] err_t;

  localparam err_t ERR_OK       = 3'd0;
  localparam err_t ERR_START    = 3'd1;
  localparam err_t ERR_NO_TERM  = 3'd2;
  localparam err_t ERR_CHECKSUM = 3'd3;
  localparam err_t ERR_DEVICE   = 3'd4;
  localparam err_t ERR_ARGS     = 3'd5;

  localparam logic [2:0] CFG_START = 3'd0;
  localparam logic [2:0] CFG_END   = 3'd1;
  localparam logic [2:0] CFG_MOTOR = 3'd2;
  localparam logic [2:0] CFG_PWM   = 3'd3;
  localparam logic [2:0] CFG_RELAY = 3'd4;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] MISSING  = 8'hFF;

endpackage

>>> hdl/framed_command_line_parser.sv
// Framed command line parser: field scan, XOR checksum check and verdict.
// The result is registered in the output register at the transfer of the byte
// that ends the line; other bytes give no result.
// Throughput: one byte per cycle, set by the line state update;
// a waiting result that is not taken holds off the next byte.
// Reset restores the character registers to $ * M P R and clears the line state.
module framed_command_line_parser
  import fclp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] line_byte,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       accepted,
  output logic [2:0] error_code,
  output logic [7:0] device_char,
  output logic [7:0] device_number,
  output logic [7:0] command_char,
  output logic [7:0] value_first,
  output logic [7:0] value_second
);

  logic [7:0] start_char, end_char, motor_char, pwm_char, relay_char;

  phase_t      phase, phase_next;
  logic [7:0]  xor_sum, xor_sum_next;
  logic [2:0]  field_index, field_index_next;
  logic [7:0]  number_acc, number_acc_next;
  logic [2:0]  fields_filled, fields_filled_next;
  logic        scan_stopped, scan_stopped_next;
  logic [7:0]  held_device, held_device_next;
  logic [7:0]  held_number, held_number_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  held_value0, held_value0_next;
  logic [7:0]  held_value1, held_value1_next;
  logic [15:0] sent_checksum, sent_checksum_next;
  logic        hex_seen, hex_seen_next;
  logic        need_comma, need_comma_next;
  logic        digits_seen, digits_seen_next;

  logic       commit, comma_after, is_digit, hex_ok, four_field, in_xfer;
  logic [3:0] hex_nib;
  logic [2:0] filled_inc, field_limit;
  err_t       verdict;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;

  assign is_digit   = (line_byte >= CH_ZERO) && (line_byte <= CH_NINE);
  assign four_field = (held_device == pwm_char) || (held_device == relay_char);

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'd0;
    if (is_digit) begin
      hex_nib = line_byte[3:0];
    end else if ((line_byte >= CH_LA && line_byte <= CH_LF) ||
                 (line_byte >= CH_UA && line_byte <= CH_UF)) begin
      hex_nib = line_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    phase_next         = phase;
    xor_sum_next       = xor_sum;
    field_index_next   = field_index;
    number_acc_next    = number_acc;
    fields_filled_next = fields_filled;
    scan_stopped_next  = scan_stopped;
    held_device_next   = held_device;
    held_number_next   = held_number;
    held_command_next  = held_command;
    held_value0_next   = held_value0;
    held_value1_next   = held_value1;
    sent_checksum_next = sent_checksum;
    hex_seen_next      = hex_seen;
    need_comma_next    = need_comma;
    digits_seen_next   = digits_seen;
    commit             = 1'b0;
    comma_after        = 1'b0;
    filled_inc         = fields_filled + 3'd1;
    field_limit        = four_field ? 3'd4 : 3'd5;

    unique case (phase)
      PH_START: begin
        phase_next = (line_byte == start_char) ? PH_BODY : PH_BAD;
      end
      PH_BODY: begin
        if (line_byte == end_char) begin
          phase_next = PH_HEX;
          commit = !scan_stopped && field_index != 3'd0 && !need_comma &&
                   field_index != 3'd2 && digits_seen;
        end else begin
          xor_sum_next = xor_sum ^ line_byte;
          if (!scan_stopped) begin
            if (field_index == 3'd0) begin
              held_device_next   = line_byte;
              fields_filled_next = 3'd1;
              field_index_next   = 3'd1;
              need_comma_next    = 1'b1;
            end else if (need_comma) begin
              if (line_byte == CH_COMMA) need_comma_next = 1'b0;
              else scan_stopped_next = 1'b1;
            end else if (field_index == 3'd2) begin
              held_command_next  = line_byte;
              fields_filled_next = filled_inc;
              field_index_next   = 3'd3;
              need_comma_next    = 1'b1;
            end else if (is_digit) begin
              number_acc_next  = {number_acc[4:0], 3'b000} + {number_acc[6:0], 1'b0}
                               + {4'd0, line_byte[3:0]};
              digits_seen_next = 1'b1;
            end else if (!digits_seen) begin
              scan_stopped_next = 1'b1;
            end else begin
              commit      = 1'b1;
              comma_after = 1'b1;
            end
          end
        end
      end
      PH_HEX: begin
        if (hex_ok) begin
          sent_checksum_next = {sent_checksum[11:0], hex_nib};
          hex_seen_next      = 1'b1;
        end else begin
          phase_next = PH_TAIL;
        end
      end
      PH_TAIL, PH_BAD: begin
      end
      default: begin
      end
    endcase

    if (commit) begin
      priority if (field_index == 3'd1) held_number_next = number_acc;
      else if (field_index == 3'd3) held_value0_next = number_acc;
      else held_value1_next = number_acc;
      fields_filled_next = filled_inc;
      number_acc_next    = 8'd0;
      digits_seen_next   = 1'b0;
      field_index_next   = field_index + 3'd1;
      if (filled_inc >= field_limit) begin
        scan_stopped_next = 1'b1;
      end else begin
        need_comma_next = 1'b1;
        if (comma_after) begin
          if (line_byte == CH_COMMA) need_comma_next = 1'b0;
          else scan_stopped_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    priority if (phase_next == PH_START || phase_next == PH_BAD) verdict = ERR_START;
    else if (phase_next == PH_BODY) verdict = ERR_NO_TERM;
    else if (!hex_seen_next || sent_checksum_next != {8'd0, xor_sum_next})
      verdict = ERR_CHECKSUM;
    else if (fields_filled_next == 3'd0) verdict = ERR_DEVICE;
    else if (held_device_next == motor_char)
      verdict = (fields_filled_next == 3'd3 || fields_filled_next == 3'd5) ? ERR_OK : ERR_ARGS;
    else if (held_device_next == pwm_char || held_device_next == relay_char)
      verdict = (fields_filled_next == 3'd3 || fields_filled_next == 3'd4) ? ERR_OK : ERR_ARGS;
    else verdict = ERR_DEVICE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= 8'd36;
      end_char   <= 8'd42;
      motor_char <= 8'd77;
      pwm_char   <= 8'd80;
      relay_char <= 8'd82;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START: start_char <= cfg_data;
        CFG_END:   end_char   <= cfg_data;
        CFG_MOTOR: motor_char <= cfg_data;
        CFG_PWM:   pwm_char   <= cfg_data;
        CFG_RELAY: relay_char <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_xfer && line_end)) begin
      phase         <= PH_START;
      xor_sum       <= 8'd0;
      field_index   <= 3'd0;
      number_acc    <= 8'd0;
      fields_filled <= 3'd0;
      scan_stopped  <= 1'b0;
      held_device   <= 8'd0;
      held_number   <= MISSING;
      held_command  <= 8'd0;
      held_value0   <= MISSING;
      held_value1   <= MISSING;
      sent_checksum <= 16'd0;
      hex_seen      <= 1'b0;
      need_comma    <= 1'b0;
      digits_seen   <= 1'b0;
    end else if (in_xfer) begin
      phase         <= phase_next;
      xor_sum       <= xor_sum_next;
      field_index   <= field_index_next;
      number_acc    <= number_acc_next;
      fields_filled <= fields_filled_next;
      scan_stopped  <= scan_stopped_next;
      held_device   <= held_device_next;
      held_number   <= held_number_next;
      held_command  <= held_command_next;
      held_value0   <= held_value0_next;
      held_value1   <= held_value1_next;
      sent_checksum <= sent_checksum_next;
      hex_seen      <= hex_seen_next;
      need_comma    <= need_comma_next;
      digits_seen   <= digits_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && line_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && line_end) begin
      accepted      <= (verdict == ERR_OK);
      error_code    <= verdict;
      device_char   <= held_device_next;
      device_number <= held_number_next;
      command_char  <= held_command_next;
      value_first   <= held_value0_next;
      value_second  <= held_value1_next;
    end
  end

endmodule

>>> sim/fclp_checker.sv
// Checker for the framed command line parser: line predictor and result compare.
`timescale 1ns / 100ps

module fclp_checker
  import fclp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] line_byte,
  input  logic       line_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       accepted,
  input  logic [2:0] error_code,
  input  logic [7:0] device_char,
  input  logic [7:0] device_number,
  input  logic [7:0] command_char,
  input  logic [7:0] value_first,
  input  logic [7:0] value_second,
  output int         fail_count,
  output int         pending_cnt
);

  typedef struct packed {
    logic       accepted;
    err_t       error_code;
    logic [7:0] device_char;
    logic [7:0] device_number;
    logic [7:0] command_char;
    logic [7:0] value_first;
    logic [7:0] value_second;
  } line_verdict_t;

  logic [7:0] ch_start = 8'h24;
  logic [7:0] ch_end = 8'h2A;
  logic [7:0] ch_motor = 8'h4D;
  logic [7:0] ch_pwm = 8'h50;
  logic [7:0] ch_relay = 8'h52;

  phase_t      ln_phase;
  logic [7:0]  ln_xor;
  logic [2:0]  ln_field;
  logic [15:0] ln_acc;
  logic [2:0]  ln_filled;
  bit          ln_stopped;
  logic [7:0]  ln_device;
  logic [7:0]  ln_number;
  logic [7:0]  ln_command;
  logic [7:0]  ln_value [0:1];
  logic [15:0] ln_sent_sum;
  bit          ln_hex_seen;
  bit          ln_need_comma;
  bit          ln_digits;

  line_verdict_t expected_verdicts[$];
  int mismatches = 0;

  assign fail_count = mismatches;

  function void clear_line();
    ln_phase = PH_START;
    ln_xor = 8'h00;
    ln_field = 3'd0;
    ln_acc = 16'h0000;
    ln_filled = 3'd0;
    ln_stopped = 1'b0;
    ln_device = 8'h00;
    ln_number = MISSING;
    ln_command = 8'h00;
    ln_value[0] = MISSING;
    ln_value[1] = MISSING;
    ln_sent_sum = 16'h0000;
    ln_hex_seen = 1'b0;
    ln_need_comma = 1'b0;
    ln_digits = 1'b0;
  endfunction

  function bit four_field(input logic [7:0] d);
    return d == ch_pwm || d == ch_relay;
  endfunction

  function void commit_number();
    if (ln_field == 3'd1)
      ln_number = ln_acc[7:0];
    else if (ln_field == 3'd3)
      ln_value[0] = ln_acc[7:0];
    else
      ln_value[1] = ln_acc[7:0];
    ln_filled++;
    ln_acc = 16'h0000;
    ln_digits = 1'b0;
    ln_field++;
    if (ln_filled >= (four_field(ln_device) ? 3'd4 : 3'd5))
      ln_stopped = 1'b1;
    else
      ln_need_comma = 1'b1;
  endfunction

  function void scan_char(input logic [7:0] c);
    if (ln_stopped)
      return;
    if (ln_field == 3'd0) begin
      ln_device = c;
      ln_filled = 3'd1;
      ln_field = 3'd1;
      ln_need_comma = 1'b1;
      return;
    end
    if (ln_need_comma) begin
      if (c == CH_COMMA)
        ln_need_comma = 1'b0;
      else
        ln_stopped = 1'b1;
      return;
    end
    if (ln_field == 3'd2) begin
      ln_command = c;
      ln_filled++;
      ln_field = 3'd3;
      ln_need_comma = 1'b1;
      return;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      ln_acc = ln_acc * 16'd10 + 16'(c - CH_ZERO);
      ln_digits = 1'b1;
      return;
    end
    if (!ln_digits) begin
      ln_stopped = 1'b1;
      return;
    end
    commit_number();
    if (!ln_stopped) begin
      if (c == CH_COMMA)
        ln_need_comma = 1'b0;
      else
        ln_stopped = 1'b1;
    end
  endfunction

  function int hex_nibble(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function err_t line_error();
    if (ln_phase == PH_START || ln_phase == PH_BAD) return ERR_START;
    if (ln_phase == PH_BODY) return ERR_NO_TERM;
    if (!ln_hex_seen || ln_sent_sum != {8'h00, ln_xor}) return ERR_CHECKSUM;
    if (ln_filled == 3'd0) return ERR_DEVICE;
    if (ln_device == ch_motor)
      return (ln_filled == 3'd3 || ln_filled == 3'd5) ? ERR_OK : ERR_ARGS;
    if (four_field(ln_device))
      return (ln_filled == 3'd3 || ln_filled == 3'd4) ? ERR_OK : ERR_ARGS;
    return ERR_DEVICE;
  endfunction

  // Advances the line state by one byte; returns 1 when the byte closes the line.
  function bit parse_byte(input logic [7:0] c, input bit last, output line_verdict_t v);
    int   nib;
    err_t e;
    case (ln_phase)
      PH_START: ln_phase = (c == ch_start) ? PH_BODY : PH_BAD;
      PH_BODY: begin
        if (c == ch_end) begin
          if (!ln_stopped && ln_field != 3'd0 && !ln_need_comma && ln_field != 3'd2 &&
              ln_digits)
            commit_number();
          ln_phase = PH_HEX;
        end else begin
          ln_xor ^= c;
          scan_char(c);
        end
      end
      PH_HEX: begin
        nib = hex_nibble(c);
        if (nib >= 0) begin
          ln_sent_sum = {ln_sent_sum[11:0], 4'(nib)};
          ln_hex_seen = 1'b1;
        end else begin
          ln_phase = PH_TAIL;
        end
      end
      default: ;
    endcase
    v = '0;
    if (!last)
      return 1'b0;
    e = line_error();
    v = '{e == ERR_OK, e, ln_device, ln_number, ln_command, ln_value[0], ln_value[1]};
    clear_line();
    return 1'b1;
  endfunction

  initial clear_line();

  always @(posedge clk) begin
    line_verdict_t got, want;
    if (rst) begin
      ch_start = 8'h24;
      ch_end = 8'h2A;
      ch_motor = 8'h4D;
      ch_pwm = 8'h50;
      ch_relay = 8'h52;
      clear_line();
      expected_verdicts.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{accepted, error_code, device_char, device_number, command_char,
                value_first, value_second};
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with none pending: acc=%0d err=%0d", $realtime,
                     got.accepted, got.error_code);
        end else begin
          want = expected_verdicts.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch exp acc=%0d err=%0d dev=%02h num=%0d cmd=%02h ",
                        "v1=%0d v2=%0d / got acc=%0d err=%0d dev=%02h num=%0d cmd=%02h ",
                        "v1=%0d v2=%0d"}, $realtime,
                       want.accepted, want.error_code, want.device_char, want.device_number,
                       want.command_char, want.value_first, want.value_second,
                       got.accepted, got.error_code, got.device_char, got.device_number,
                       got.command_char, got.value_first, got.value_second);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START: ch_start = cfg_data;
          CFG_END:   ch_end = cfg_data;
          CFG_MOTOR: ch_motor = cfg_data;
          CFG_PWM:   ch_pwm = cfg_data;
          CFG_RELAY: ch_relay = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (parse_byte(line_byte, line_end, want))
          expected_verdicts.push_back(want);
      end
    end
    pending_cnt <= expected_verdicts.size();
  end

endmodule

>>> sim/tb_framed_command_line_parser.sv
// Testbench top for the framed command line parser: line stimulus and verdict.
`timescale 1ns / 100ps

module tb_framed_command_line_parser;
  import fclp_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = CFG_START;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] line_byte = 8'h00;
  logic       line_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       accepted;
  logic [2:0] error_code;
  logic [7:0] device_char;
  logic [7:0] device_number;
  logic [7:0] command_char;
  logic [7:0] value_first;
  logic [7:0] value_second;

  int fail_count;
  int pending_cnt;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int results_taken = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int bytes_sent = 0;

  logic [7:0] reg_val [0:4] = '{8'h24, 8'h2A, 8'h4D, 8'h50, 8'h52};
  logic [7:0] line_buf[$];

  framed_command_line_parser uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .line_byte(line_byte), .line_end(line_end),
    .out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
    .error_code(error_code), .device_char(device_char), .device_number(device_number),
    .command_char(command_char), .value_first(value_first), .value_second(value_second)
  );

  fclp_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .line_byte(line_byte), .line_end(line_end),
    .out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
    .error_code(error_code), .device_char(device_char), .device_number(device_number),
    .command_char(command_char), .value_first(value_first), .value_second(value_second),
    .fail_count(fail_count), .pending_cnt(pending_cnt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls plus one long hold-off to back the block up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        results_taken++;
      if (!hold_done && results_taken >= 12) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    line_byte <= b;
    line_end <= last;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_byte(line_buf[i], i == line_buf.size() - 1);
    bytes_sent += line_buf.size();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      line_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] line_xor();
    logic [7:0] sum;
    sum = 8'h00;
    for (int i = 1; i < line_buf.size(); i++) begin
      if (line_buf[i] == reg_val[CFG_END])
        break;
      sum ^= line_buf[i];
    end
    return sum;
  endfunction

  task automatic add_hex(input logic [19:0] hv, input int nd);
    logic [3:0] nib;
    for (int i = nd - 1; i >= 0; i--) begin
      nib = hv[4*i +: 4];
      if (nib < 4'd10)
        line_buf.push_back(CH_ZERO + 8'(nib));
      else
        line_buf.push_back(($urandom_range(1) ? CH_UA : CH_LA) + 8'(nib - 4'd10));
    end
  endtask

  task automatic add_number();
    int nd;
    nd = ($urandom_range(19) == 0) ? 0 :
         ($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
    repeat (nd)
      line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic build_random_line();
    int         kind, nf, r;
    logic [7:0] sum;
    logic [19:0] hv;
    line_buf.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 12))
        line_buf.push_back(8'($urandom_range(255)));
      if ($urandom_range(1))
        line_buf[0] = reg_val[CFG_START];
    end else begin
      line_buf.push_back(reg_val[CFG_START]);
      r = $urandom_range(9);
      if (r < 3)
        line_buf.push_back(reg_val[CFG_MOTOR]);
      else if (r < 5)
        line_buf.push_back(reg_val[CFG_PWM]);
      else if (r < 7)
        line_buf.push_back(reg_val[CFG_RELAY]);
      else
        line_buf.push_back(8'($urandom_range(255)));
      nf = $urandom_range(1, 6);
      if (nf >= 2) begin
        line_buf.push_back(CH_COMMA);
        add_number();
      end
      if (nf >= 3) begin
        line_buf.push_back(CH_COMMA);
        if ($urandom_range(4) != 0)
          line_buf.push_back(CH_UA + 8'($urandom_range(25)));
        else
          line_buf.push_back(8'($urandom_range(255)));
      end
      for (int k = 4; k <= nf; k++) begin
        line_buf.push_back(CH_COMMA);
        add_number();
      end
      sum = line_xor();
      if ($urandom_range(19) != 0)
        line_buf.push_back(reg_val[CFG_END]);
      if ($urandom_range(9) == 0)
        sum = 8'($urandom_range(255));
      case ($urandom_range(9))
        0: ;
        1: add_hex({12'h000, sum}, 4);
        2: add_hex({4'($urandom_range(15)), 8'h00, sum}, 5);
        3: add_hex({12'h000, sum}, (sum < 8'h10) ? 1 : 2);
        default: add_hex({12'h000, sum}, 2);
      endcase
      case ($urandom_range(3))
        1: begin
          line_buf.push_back(8'h0D);
          line_buf.push_back(8'h0A);
        end
        2: repeat ($urandom_range(1, 3))
             line_buf.push_back(8'($urandom_range(255)));
        default: ;
      endcase
      if ($urandom_range(9) == 0)
        line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
    end
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    if (idx <= CFG_RELAY)
      reg_val[idx] = val;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0)
      @(posedge clk);
  endtask

  task automatic apply_setting(input int ph);
    case (ph)
      1: begin
        write_cfg(CFG_START, 8'h00);
        write_cfg(CFG_END, 8'hFF);
        write_cfg(CFG_MOTOR, 8'h80);
        write_cfg(CFG_PWM, 8'h00);
        write_cfg(CFG_RELAY, 8'hFE);
      end
      2: begin
        write_cfg(CFG_START, 8'hFF);
        write_cfg(CFG_END, 8'h00);
        write_cfg(CFG_MOTOR, 8'h01);
        write_cfg(CFG_PWM, 8'hFE);
        write_cfg(CFG_RELAY, 8'h7F);
      end
      default: begin
        write_cfg(CFG_START, 8'h23);
        write_cfg(CFG_END, 8'h2A);
        write_cfg(CFG_MOTOR, 8'h4D);
        write_cfg(CFG_PWM, 8'h70);
        write_cfg(CFG_RELAY, 8'h52);
        write_cfg(3'd5, 8'hA5);
        write_cfg(3'd7, 8'h5A);
      end
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines at reset settings
    line_buf = '{8'hFF};
    send_line();
    line_buf = '{8'h00};
    send_line();
    line_buf.delete();
    add_text("$");
    send_line();
    line_buf.delete();
    add_text("$*0");
    send_line();
    line_buf.delete();
    add_text("$R,7,A*");
    add_hex({12'h000, line_xor()}, 2);
    send_line();
    line_buf.delete();
    add_text("$M*");
    send_line();
    line_buf.delete();
    add_text("$M,1");
    send_line();

    bytes_sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        wait_drained();
        repeat (4) @(posedge clk);
        apply_setting(ph);
      end
      while (bytes_sent < (ph + 1) * 165) begin
        if (bytes_sent < 220) begin
          send_idle_pct = 30;
          recv_stall_pct = 86;
        end else if (bytes_sent < 440) begin
          send_idle_pct = 86;
          recv_stall_pct = 30;
        end else begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        build_random_line();
        send_line();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("tb_framed_command_line_parser: done, clean");
    else
      $display("tb_framed_command_line_parser: done, errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_framed_command_line_parser: done, errors");
    $finish;
  end

endmodule

>>> sim.f
hdl/fclp_pkg.sv
hdl/framed_command_line_parser.sv
sim/fclp_checker.sv
sim/tb_framed_command_line_parser.sv
